@@ design/delay_line_pitch_shifter_unit_macros.svh @@
// Assertion macros shared by the pitch shifter checker.
// Included by design/dlps_checker.sv; no other dependencies.
`ifndef DELAY_LINE_PITCH_SHIFTER_UNIT_MACROS_SVH
`define DELAY_LINE_PITCH_SHIFTER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DLPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dlps assertion failed");

// Property checked on every clock edge, reset included.
`define DLPS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("dlps assertion failed");

`endif

@@ design/dlps_pkg.sv @@
// Shared constants, types and helpers of the delay line pitch shifter.
// No dependencies; imported by every module of the block.
package dlps_pkg;

   localparam int STORE_DEPTH   = 4096;
   localparam int FADE_LENGTH   = 256;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int SIZE_W        = ADDR_W + 1;
   localparam int POS_FRAC      = 12;
   localparam int POS_W         = SIZE_W + POS_FRAC;
   localparam int ROUND_HALF    = 2048;

   localparam int SAMPLE_W      = 24;
   localparam int RATIO_W       = 16;
   localparam int USED_SIZE_W   = 13;
   localparam int WEIGHT_W      = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int FIFO_DEPTH    = 4;
   localparam int MAX_IN_FLIGHT = FIFO_DEPTH + 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_RATIO  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USED_SIZE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_WEIGHT = 2'd2;

   localparam logic [RATIO_W-1:0]     RATIO_UNITY      = 16'd4096;
   localparam logic [RATIO_W-1:0]     RATIO_RESET      = 16'd4096;
   localparam logic [USED_SIZE_W-1:0] USED_SIZE_RESET  = 13'd4096;
   localparam logic [WEIGHT_W-1:0]    WEIGHT_FULL      = 16'd32768;

   // High-pass biquad coefficients, Q2.30
   localparam logic signed [31:0] COEF_B0 = 32'sd1058936852;
   localparam logic signed [31:0] COEF_B1 = 32'sd2117873703;
   localparam logic signed [31:0] COEF_A1 = 32'sd2117669563;
   localparam logic signed [31:0] COEF_A2 = 32'sd1044336019;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;

   typedef struct packed {
      logic       valid;
      addr_type   wr_addr;
      sample_type wr_data;
      addr_type   tap1;
      addr_type   tap2;
      weight_type weight;
   } tap_cmd_type;

   function automatic sample_type sat_sample(input logic signed [63:0] v);
      sample_type r;
      if (v > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/dlps_front.sv @@
// Input side: accepts samples and queues them for the filter core.
// Depends on dlps_pkg.
module dlps_front import dlps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   output logic                q_valid,
   input  logic                q_ready,
   output sample_type          q_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   sample_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign req_tready = (count_ff != CNT_W'(FIFO_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_data     = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

@@ design/dlps_core.sv @@
// Filter core: biquad high-pass, read position, tap addresses and crossfade weight.
// Holds the configuration registers. Depends on dlps_pkg.
module dlps_core import dlps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  sample_type             q_data,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output tap_cmd_type            cmd,
   input  logic                   cmd_ready
);

   localparam int PROD_W = SAMPLE_W + 32;
   localparam int ACC_W  = PROD_W + 3;
   localparam int CMP_W  = ((USED_SIZE_W > SIZE_W) ? USED_SIZE_W : SIZE_W) + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SUM    = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [RATIO_W-1:0]     pitch_ff, pitch_in;
   logic [USED_SIZE_W-1:0] used_size_ff, used_size_in;
   weight_type             fade_ff, fade_in;
   addr_type               wr_idx_ff, wr_idx_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   sample_type             x1_ff, x1_in, x2_ff, x2_in;
   sample_type             y1_ff, y1_in, y2_ff, y2_in;

   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   sample_type               x_ff;
   addr_type                 wi_ff, tap1_ff, tap2_ff;
   weight_type               weight_ff;

   logic                     load_prod, load_sum;
   logic [SIZE_W-1:0]        size, half;
   logic [POS_W-1:0]         pos_rnd, pos_next, pos_next_rnd;
   logic [SIZE_W-1:0]        rnd_idx;
   addr_type                 tap1, tap2, wi;
   logic [SIZE_W-1:0]        wi_inc;
   logic signed [ADDR_W:0]   d1, d2;
   weight_type               weight;
   logic signed [ACC_W-1:0]  acc_rnd;
   sample_type               y;

   function automatic weight_type fade_of(input addr_type d);
      logic [ADDR_W+15:0] scaled;
      scaled = {d, 15'b0};
      return WEIGHT_W'(scaled / FADE_LENGTH);
   endfunction

   // Size in use, clamped to at least 2 and at most the store depth
   always_comb begin
      if (used_size_ff < USED_SIZE_W'(2)) begin
         size = SIZE_W'(2);
      end else if (CMP_W'(used_size_ff) > CMP_W'(STORE_DEPTH)) begin
         size = SIZE_W'(STORE_DEPTH);
      end else begin
         size = SIZE_W'(used_size_ff);
      end
      half = size >> 1;
   end

   // Tap addresses and crossfade weight
   always_comb begin
      pos_rnd = pos_ff + POS_W'(ROUND_HALF);
      rnd_idx = pos_rnd[POS_W-1:POS_FRAC];
      tap1    = (rnd_idx >= size) ? '0 : rnd_idx[ADDR_W-1:0];
      tap2    = ({1'b0, tap1} >= half) ? tap1 - half[ADDR_W-1:0] : tap1 + half[ADDR_W-1:0];
      wi      = ({1'b0, wr_idx_ff} >= size) ? '0 : wr_idx_ff;
      d1      = $signed({1'b0, wi}) - $signed({1'b0, tap1});
      d2      = $signed({1'b0, wi}) - $signed({1'b0, tap2});
      weight  = fade_ff;
      if (d1 >= 0 && d1 <= FADE_LENGTH && pitch_ff != RATIO_UNITY) begin
         weight = fade_of(d1[ADDR_W-1:0]);
      end else if (d1 == 0) begin
         weight = '0;
      end
      if (d2 >= 0 && d2 <= FADE_LENGTH && pitch_ff != RATIO_UNITY) begin
         weight = WEIGHT_FULL - fade_of(d2[ADDR_W-1:0]);
      end else if (d2 == 0) begin
         weight = WEIGHT_FULL;
      end
   end

   // Filter output, rounded at bit 30 and saturated
   always_comb begin
      acc_rnd = acc_ff + (ACC_W'(1) <<< 29);
      y       = sat_sample(64'(acc_rnd >>> 30));
   end

   always_comb begin
      wi_inc       = {1'b0, wi_ff} + 1'b1;
      pos_next     = pos_ff + POS_W'(pitch_ff);
      pos_next_rnd = pos_next + POS_W'(ROUND_HALF);
   end

   always_comb begin
      state_in     = state_ff;
      pitch_in     = pitch_ff;
      used_size_in = used_size_ff;
      fade_in      = fade_ff;
      wr_idx_in    = wr_idx_ff;
      pos_in       = pos_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      q_ready      = 1'b0;
      load_prod    = 1'b0;
      load_sum     = 1'b0;
      cmd.valid    = 1'b0;
      cmd.wr_addr  = wi_ff;
      cmd.wr_data  = y;
      cmd.tap1     = tap1_ff;
      cmd.tap2     = tap2_ff;
      cmd.weight   = weight_ff;

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               load_prod = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            load_sum = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.valid = 1'b1;
            if (cmd_ready) begin
               fade_in   = weight_ff;
               x1_in     = x_ff;
               x2_in     = x1_ff;
               y1_in     = y;
               y2_in     = y1_ff;
               wr_idx_in = (wi_inc == size) ? '0 : wi_inc[ADDR_W-1:0];
               pos_in    = (pos_next_rnd[POS_W-1:POS_FRAC] >= size) ? '0 : pos_next;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_PITCH_RATIO: begin
               pitch_in = csr_wdata[RATIO_W-1:0];
            end
            CSR_USED_SIZE: begin
               used_size_in = csr_wdata[USED_SIZE_W-1:0];
            end
            CSR_START_WEIGHT: begin
               fade_in = (csr_wdata > WEIGHT_FULL) ? WEIGHT_FULL : csr_wdata[WEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pitch_ff     <= RATIO_RESET;
         used_size_ff <= USED_SIZE_RESET;
         fade_ff      <= '0;
         wr_idx_ff    <= '0;
         pos_ff       <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         pitch_ff     <= pitch_in;
         used_size_ff <= used_size_in;
         fade_ff      <= fade_in;
         wr_idx_ff    <= wr_idx_in;
         pos_ff       <= pos_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         x_ff  <= q_data;
         p0_ff <= PROD_W'(q_data) * PROD_W'(COEF_B0);
         p1_ff <= PROD_W'(x1_ff) * PROD_W'(COEF_B1);
         p2_ff <= PROD_W'(x2_ff) * PROD_W'(COEF_B0);
         p3_ff <= PROD_W'(y1_ff) * PROD_W'(COEF_A1);
         p4_ff <= PROD_W'(y2_ff) * PROD_W'(COEF_A2);
      end
      if (load_sum) begin
         acc_ff    <= ACC_W'(p0_ff) - ACC_W'(p1_ff) + ACC_W'(p2_ff)
                      + ACC_W'(p3_ff) - ACC_W'(p4_ff);
         wi_ff     <= wi;
         tap1_ff   <= tap1;
         tap2_ff   <= tap2;
         weight_ff <= weight;
      end
   end

endmodule

@@ design/dlps_tap.sv @@
// Delay store and crossfade mixer: writes the filtered sample, reads both taps,
// mixes and saturates into the output register. Depends on dlps_pkg.
module dlps_tap import dlps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  tap_cmd_type         cmd,
   output logic                cmd_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata
);

   localparam int MIX_W = SAMPLE_W + WEIGHT_W + 1;

   sample_type        store [STORE_DEPTH];
   logic [SIZE_W-1:0] fill_ff, fill_in;
   sample_type        rd1_ff, rd2_ff;

   logic              r_valid_ff, r_valid_in;
   logic              r_fwd1_ff, r_fwd2_ff, r_zero1_ff, r_zero2_ff;
   sample_type        r_y_ff;
   weight_type        r_w_ff;

   logic                    p_valid_ff, p_valid_in;
   logic signed [MIX_W-1:0] p1_ff, p2_ff, p1_in, p2_in;

   logic              o_valid_ff, o_valid_in;
   sample_type        o_data_ff, o_data_in;

   logic              accept, o_free, p_adv, p_free, r_adv;
   sample_type        t1, t2;
   logic signed [WEIGHT_W:0] w1, w2;
   logic signed [MIX_W:0]    mix_sum;

   assign o_free    = !o_valid_ff || rsp_tready;
   assign p_adv     = p_valid_ff && o_free;
   assign p_free    = !p_valid_ff || p_adv;
   assign r_adv     = r_valid_ff && p_free;
   assign cmd_ready = !r_valid_ff || r_adv;
   assign accept    = cmd.valid && cmd_ready;

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;

   always_comb begin
      fill_in = fill_ff;
      if (accept && ({1'b0, cmd.wr_addr} >= fill_ff)) begin
         fill_in = {1'b0, cmd.wr_addr} + 1'b1;
      end
      r_valid_in = accept ? 1'b1 : (r_adv ? 1'b0 : r_valid_ff);
      p_valid_in = r_adv ? 1'b1 : (p_adv ? 1'b0 : p_valid_ff);
      o_valid_in = p_adv ? 1'b1 : (rsp_tready ? 1'b0 : o_valid_ff);
   end

   // Tap select: the sample written in the same transfer wins, unwritten entries read zero
   always_comb begin
      t1      = r_fwd1_ff ? r_y_ff : (r_zero1_ff ? '0 : rd1_ff);
      t2      = r_fwd2_ff ? r_y_ff : (r_zero2_ff ? '0 : rd2_ff);
      w1      = $signed({1'b0, r_w_ff});
      w2      = $signed((WEIGHT_W + 1)'(WEIGHT_FULL) - {1'b0, r_w_ff});
      p1_in   = MIX_W'(t1) * MIX_W'(w1);
      p2_in   = MIX_W'(t2) * MIX_W'(w2);
      mix_sum = (MIX_W + 1)'(p1_ff) + (MIX_W + 1)'(p2_ff) + (MIX_W + 1)'(16384);
      o_data_in = sat_sample(64'(mix_sum >>> 15));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store[cmd.wr_addr] <= cmd.wr_data;
         rd1_ff             <= store[cmd.tap1];
         rd2_ff             <= store[cmd.tap2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         r_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         r_valid_ff <= r_valid_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r_fwd1_ff  <= (cmd.tap1 == cmd.wr_addr);
         r_fwd2_ff  <= (cmd.tap2 == cmd.wr_addr);
         r_zero1_ff <= ({1'b0, cmd.tap1} >= fill_ff);
         r_zero2_ff <= ({1'b0, cmd.tap2} >= fill_ff);
         r_y_ff     <= cmd.wr_data;
         r_w_ff     <= cmd.weight;
      end
      if (r_adv) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (p_adv) begin
         o_data_ff <= o_data_in;
      end
   end

endmodule

@@ design/delay_line_pitch_shifter_unit.sv @@
// A sample passes the input queue, the core's product and sum registers, then the mixer's
// read, product and output registers. The core takes no new sample until the biquad feedback
// loop is done with the last (multiply, sum, round and commit; commit waits on the mixer).
// Reset (synchronous, active high) clears queues, filter history, position, write index
// and registers; the store reads as zero up to a fill mark, so there is no clearing pass.
module delay_line_pitch_shifter_unit import dlps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [23:0] sample_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]    rsp_tdata,   // [23:0] sample_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        q_valid, q_ready;
   sample_type  q_data;
   tap_cmd_type tap_cmd;
   logic        tap_ready;

   assign csr_ready = 1'b1;

   dlps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data)
   );

   dlps_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (tap_cmd),
      .cmd_ready (tap_ready)
   );

   dlps_tap u_tap (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tap_cmd),
      .cmd_ready  (tap_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/dlps_checker.sv @@
// Port-level checker for the pitch shifter, bound to the top level.
// Depends on dlps_pkg and delay_line_pitch_shifter_unit_macros.svh.
`include "delay_line_pitch_shifter_unit_macros.svh"

module dlps_checker import dlps_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SAMPLE_W-1:0]    rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_IN_FLIGHT + 1);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             in_xfer, out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (in_xfer && !out_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (out_xfer && !in_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DLPS_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)
   `DLPS_ASSERT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `DLPS_ASSERT(a_no_spurious_rsp, clock, reset, out_xfer |-> pending_ff != '0)
   `DLPS_ASSERT(a_in_flight_bound, clock, reset, pending_ff <= CNT_W'(MAX_IN_FLIGHT))

endmodule

bind delay_line_pitch_shifter_unit dlps_checker u_checker (.*);
